### rtl/stack_language_tokenizer_defines.svh
// Assertion macros used by the tokenizer scanner RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef STACK_LANGUAGE_TOKENIZER_DEFINES_SVH
`define STACK_LANGUAGE_TOKENIZER_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SLT_ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("slt check failed");

// Next-cycle implication, disabled during reset.
`define SLT_ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("slt check failed");

`endif

### rtl/slt_pkg.sv
// Types, codes and character helpers for the stack-language tokenizer.
// No dependencies; used by every tokenizer module.
`default_nettype none

package slt_pkg;

  localparam int POS_BITS_DEF = 16;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_WORD,
    MODE_VALUE,
    MODE_COMMENT,
    MODE_DOTQ,
    MODE_STRING,
    MODE_DROP
  } mode_t;

  localparam logic RK_TOKEN = 1'b0;
  localparam logic RK_FAULT = 1'b1;

  localparam logic [4:0] TK_VALUE  = 5'd0;
  localparam logic [4:0] TK_WORD   = 5'd1;
  localparam logic [4:0] TK_STRING = 5'd2;
  localparam logic [4:0] TK_COLON  = 5'd3;
  localparam logic [4:0] TK_SEMI   = 5'd4;
  localparam logic [4:0] TK_DOT    = 5'd5;
  localparam logic [4:0] TK_PLUS   = 5'd6;
  localparam logic [4:0] TK_MINUS  = 5'd7;
  localparam logic [4:0] TK_MUL    = 5'd8;
  localparam logic [4:0] TK_DIV    = 5'd9;
  localparam logic [4:0] TK_EQ     = 5'd10;
  localparam logic [4:0] TK_LT     = 5'd11;
  localparam logic [4:0] TK_GT     = 5'd12;
  localparam logic [4:0] TK_SWAP   = 5'd13;
  localparam logic [4:0] TK_DUP    = 5'd14;
  localparam logic [4:0] TK_ROT    = 5'd15;
  localparam logic [4:0] TK_IF     = 5'd16;
  localparam logic [4:0] TK_THEN   = 5'd17;
  localparam logic [4:0] TK_ELSE   = 5'd18;

  localparam logic [2:0] FC_VALUE  = 3'd0;
  localparam logic [2:0] FC_WORD   = 3'd1;
  localparam logic [2:0] FC_STRING = 3'd2;
  localparam logic [2:0] FC_SYMBOL = 3'd3;
  localparam logic [2:0] FC_START  = 3'd4;

  // Keyword text, first letter in the low byte
  localparam logic [31:0] KW_SWAP = 32'h7061_7773;
  localparam logic [31:0] KW_DUP  = 32'h0070_7564;
  localparam logic [31:0] KW_ROT  = 32'h0074_6F72;
  localparam logic [31:0] KW_IF   = 32'h0000_6669;
  localparam logic [31:0] KW_THEN = 32'h6E65_6874;
  localparam logic [31:0] KW_ELSE = 32'h6573_6C65;

  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_QUOTE   = 8'h22;
  localparam logic [7:0] CH_LPAREN  = 8'h28;
  localparam logic [7:0] CH_RPAREN  = 8'h29;
  localparam logic [7:0] CH_DOT     = 8'h2E;

  typedef struct packed {
    logic       vld;
    logic [7:0] text_byte;
    logic       is_final;
  } item_t;

  typedef struct packed {
    logic        result_kind;
    logic [4:0]  token_kind;
    logic [15:0] token_offset;
    logic [15:0] token_length;
    logic [2:0]  fault_code;
    logic [15:0] fault_line;
    logic [15:0] fault_column;
  } result_t;

  typedef struct packed {
    logic    vld;
    result_t res;
  } step_t;

  function automatic logic is_space(input logic [7:0] b);
    return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
  endfunction

  function automatic logic is_lower(input logic [7:0] b);
    return b >= 8'h61 && b <= 8'h7A;
  endfunction

  function automatic logic is_upper(input logic [7:0] b);
    return b >= 8'h41 && b <= 8'h5A;
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'h30 && b <= 8'h39;
  endfunction

  function automatic logic is_punct(input logic [7:0] b);
    return (b >= 8'd33 && b <= 8'd47) || (b >= 8'd58 && b <= 8'd64) ||
           (b >= 8'd91 && b <= 8'd96) || (b >= 8'd123 && b <= 8'd126);
  endfunction

  function automatic logic is_op(input logic [7:0] b);
    logic hit;
    case (b)
      8'h3A, 8'h3B, 8'h2B, 8'h2D, 8'h2A, 8'h2F, 8'h3D, 8'h3C, 8'h3E: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic [4:0] op_kind(input logic [7:0] b);
    logic [4:0] k;
    case (b)
      8'h3A:   k = TK_COLON;
      8'h3B:   k = TK_SEMI;
      8'h2B:   k = TK_PLUS;
      8'h2D:   k = TK_MINUS;
      8'h2A:   k = TK_MUL;
      8'h2F:   k = TK_DIV;
      8'h3D:   k = TK_EQ;
      8'h3C:   k = TK_LT;
      8'h3E:   k = TK_GT;
      default: k = TK_WORD;
    endcase
    return k;
  endfunction

  // len3 is the word length clipped to 7
  function automatic logic [4:0] word_kind(input logic [31:0] p, input logic [2:0] len3);
    logic [4:0] k;
    k = TK_WORD;
    if (len3 == 3'd4 && p == KW_SWAP) k = TK_SWAP;
    else if (len3 == 3'd3 && p == KW_DUP) k = TK_DUP;
    else if (len3 == 3'd3 && p == KW_ROT) k = TK_ROT;
    else if (len3 == 3'd2 && p == KW_IF) k = TK_IF;
    else if (len3 == 3'd4 && p == KW_THEN) k = TK_THEN;
    else if (len3 == 3'd4 && p == KW_ELSE) k = TK_ELSE;
    return k;
  endfunction

  function automatic result_t tok(input logic [4:0] kind, input logic [15:0] off,
                                  input logic [15:0] len);
    result_t r;
    r = '0;
    r.result_kind  = RK_TOKEN;
    r.token_kind   = kind;
    r.token_offset = off;
    r.token_length = len;
    return r;
  endfunction

  function automatic result_t flt(input logic [2:0] code, input logic [15:0] line,
                                  input logic [15:0] col);
    result_t r;
    r = '0;
    r.result_kind  = RK_FAULT;
    r.fault_code   = code;
    r.fault_line   = line;
    r.fault_column = col;
    return r;
  endfunction

endpackage

`default_nettype wire

### rtl/slt_inreg.sv
// Input register of the tokenizer: holds one source byte until the scanner takes it.
// Depends on slt_pkg.
`default_nettype none

module slt_inreg (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire logic [7:0]    in_text_byte,
  input  wire logic          in_is_final,
  input  wire logic          take,
  output slt_pkg::item_t     item_o
);

  slt_pkg::item_t item_r;
  logic           vld_nxt;

  assign in_stall = item_r.vld && !take;
  assign vld_nxt  = in_stall ? item_r.vld : in_valid;
  assign item_o   = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_r.vld <= 1'b0;
    end else begin
      item_r.vld <= vld_nxt;
    end
    if (in_valid && !in_stall) begin
      item_r.text_byte <= in_text_byte;
      item_r.is_final  <= in_is_final;
    end
  end

endmodule

`default_nettype wire

### rtl/slt_scan.sv
// Scanner state and byte step: mode, positions, word prefix, fault latch.
// Depends on slt_pkg and stack_language_tokenizer_defines.svh.
`default_nettype none
`include "stack_language_tokenizer_defines.svh"

module slt_scan #(
  parameter int POS_BITS = slt_pkg::POS_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire slt_pkg::item_t item_i,
  input  wire logic          slot_free,
  output logic               take,
  output slt_pkg::step_t     step_o
);

  localparam int WIDE = (POS_BITS > 16) ? POS_BITS : 16;
  localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};
  localparam logic [POS_BITS-1:0] POS_ONE = POS_BITS'(1);

  function automatic logic [15:0] clip16(input logic [POS_BITS-1:0] v);
    logic [WIDE-1:0] w;
    w = WIDE'(v);
    return (w > WIDE'(16'hFFFF)) ? 16'hFFFF : w[15:0];
  endfunction

  function automatic logic [POS_BITS-1:0] sat_inc(input logic [POS_BITS-1:0] v);
    return (v == POS_MAX) ? v : POS_BITS'(v + 1'b1);
  endfunction

  function automatic logic [POS_BITS-1:0] span(input logic [POS_BITS-1:0] from,
                                              input logic [POS_BITS-1:0] to);
    return (to >= from) ? POS_BITS'(to - from) : '0;
  endfunction

  function automatic logic [2:0] len3(input logic [POS_BITS-1:0] v);
    return (v > POS_BITS'(7)) ? 3'd7 : v[2:0];
  endfunction

  slt_pkg::mode_t      mode_r, mode_nxt;
  logic [POS_BITS-1:0] off_r, off_nxt;
  logic [POS_BITS-1:0] begin_r, begin_nxt;
  logic [POS_BITS-1:0] line_r, line_nxt;
  logic [POS_BITS-1:0] col_r, col_nxt;
  logic [31:0]         prefix_r, prefix_nxt;
  logic                fault_r, fault_nxt;

  logic [7:0]          b;
  logic                fin;
  logic                go;
  logic [POS_BITS-1:0] off_inc, col_inc, line_inc;
  logic [POS_BITS-1:0] len_cur, len_inc, len_start;
  logic [31:0]         prefix_add;
  logic [4:0]          kind_cur, kind_inc;
  logic                sp, lo, up, dg, pn;

  assign b    = item_i.text_byte;
  assign fin  = item_i.is_final;
  assign take = item_i.vld && slot_free;
  assign go   = take && !fault_r;

  assign sp = slt_pkg::is_space(b);
  assign lo = slt_pkg::is_lower(b);
  assign up = slt_pkg::is_upper(b);
  assign dg = slt_pkg::is_digit(b);
  assign pn = slt_pkg::is_punct(b);

  assign off_inc   = sat_inc(off_r);
  assign col_inc   = sat_inc(col_r);
  assign line_inc  = sat_inc(line_r);
  assign len_cur   = span(begin_r, off_r);
  assign len_inc   = span(begin_r, off_inc);
  assign len_start = span(off_r, off_inc);

  assign prefix_add = (len_cur < POS_BITS'(4)) ?
                      (prefix_r | ({24'h0, b} << {len_cur[1:0], 3'b000})) : prefix_r;
  assign kind_cur   = slt_pkg::word_kind(prefix_r, len3(len_cur));
  assign kind_inc   = slt_pkg::word_kind(prefix_add, len3(len_inc));

  // next state
  always_comb begin
    mode_nxt   = mode_r;
    off_nxt    = off_r;
    begin_nxt  = begin_r;
    line_nxt   = line_r;
    col_nxt    = col_r;
    prefix_nxt = prefix_r;
    fault_nxt  = fault_r;
    if (go) begin
      case (mode_r)
        slt_pkg::MODE_WORD, slt_pkg::MODE_VALUE: begin
          if (sp) begin
            mode_nxt = slt_pkg::MODE_IDLE;
            off_nxt  = off_inc;
            if (b == slt_pkg::CH_NEWLINE) begin
              line_nxt = line_inc;
              col_nxt  = POS_ONE;
            end else begin
              col_nxt = col_inc;
            end
          end else if (mode_r == slt_pkg::MODE_WORD && (lo || up)) begin
            prefix_nxt = prefix_add;
            off_nxt    = off_inc;
            col_nxt    = col_inc;
          end else if (mode_r == slt_pkg::MODE_VALUE && dg) begin
            off_nxt = off_inc;
            col_nxt = col_inc;
          end else begin
            fault_nxt = 1'b1;
          end
        end
        slt_pkg::MODE_COMMENT: begin
          off_nxt = off_inc;
          col_nxt = col_inc;
          if (b == slt_pkg::CH_RPAREN) mode_nxt = slt_pkg::MODE_IDLE;
        end
        slt_pkg::MODE_DOTQ: begin
          off_nxt = off_inc;
          col_nxt = col_inc;
          if (b == slt_pkg::CH_QUOTE) begin
            begin_nxt = off_inc;
            mode_nxt  = slt_pkg::MODE_STRING;
            if (fin) fault_nxt = 1'b1;
          end else begin
            mode_nxt = slt_pkg::MODE_IDLE;
          end
        end
        slt_pkg::MODE_STRING: begin
          off_nxt = off_inc;
          col_nxt = col_inc;
          if (b == slt_pkg::CH_QUOTE) mode_nxt = slt_pkg::MODE_DROP;
          else if (fin) fault_nxt = 1'b1;
        end
        slt_pkg::MODE_DROP: begin
          off_nxt  = off_inc;
          col_nxt  = col_inc;
          mode_nxt = slt_pkg::MODE_IDLE;
        end
        default: begin
          mode_nxt = slt_pkg::MODE_IDLE;
          if (lo) begin
            begin_nxt  = off_r;
            prefix_nxt = {24'h0, b};
            off_nxt    = off_inc;
            col_nxt    = col_inc;
            mode_nxt   = slt_pkg::MODE_WORD;
          end else if (dg) begin
            begin_nxt = off_r;
            off_nxt   = off_inc;
            col_nxt   = col_inc;
            mode_nxt  = slt_pkg::MODE_VALUE;
          end else if (b == slt_pkg::CH_LPAREN) begin
            off_nxt  = off_inc;
            col_nxt  = col_inc;
            mode_nxt = slt_pkg::MODE_COMMENT;
          end else if (pn) begin
            off_nxt = off_inc;
            col_nxt = col_inc;
            if (b == slt_pkg::CH_DOT) begin
              begin_nxt = off_r;
              if (!fin) mode_nxt = slt_pkg::MODE_DOTQ;
            end else if (slt_pkg::is_op(b)) begin
              mode_nxt = slt_pkg::MODE_DROP;
            end else begin
              fault_nxt = 1'b1;
            end
          end else if (sp) begin
            off_nxt = off_inc;
            if (b == slt_pkg::CH_NEWLINE) begin
              line_nxt = line_inc;
              col_nxt  = POS_ONE;
            end else begin
              col_nxt = col_inc;
            end
          end else begin
            fault_nxt = 1'b1;
          end
        end
      endcase
      if (fin && !fault_nxt) begin
        mode_nxt   = slt_pkg::MODE_IDLE;
        off_nxt    = '0;
        begin_nxt  = '0;
        line_nxt   = POS_ONE;
        col_nxt    = '0;
        prefix_nxt = '0;
      end
    end
  end

  // result
  always_comb begin
    step_o = '0;
    if (go) begin
      case (mode_r)
        slt_pkg::MODE_WORD: begin
          step_o.vld = 1'b1;
          if (sp)
            step_o.res = slt_pkg::tok(kind_cur, clip16(begin_r), clip16(len_cur));
          else if (lo || up)
            if (fin) step_o.res = slt_pkg::tok(kind_inc, clip16(begin_r), clip16(len_inc));
            else step_o.vld = 1'b0;
          else
            step_o.res = slt_pkg::flt(slt_pkg::FC_WORD, clip16(line_r), clip16(col_r));
        end
        slt_pkg::MODE_VALUE: begin
          step_o.vld = 1'b1;
          if (sp)
            step_o.res = slt_pkg::tok(slt_pkg::TK_VALUE, clip16(begin_r), clip16(len_cur));
          else if (dg)
            if (fin)
              step_o.res = slt_pkg::tok(slt_pkg::TK_VALUE, clip16(begin_r), clip16(len_inc));
            else step_o.vld = 1'b0;
          else
            step_o.res = slt_pkg::flt(slt_pkg::FC_VALUE, clip16(line_r), clip16(col_r));
        end
        slt_pkg::MODE_COMMENT, slt_pkg::MODE_DROP: step_o.vld = 1'b0;
        slt_pkg::MODE_DOTQ: begin
          if (b == slt_pkg::CH_QUOTE) begin
            step_o.vld = fin;
            step_o.res = slt_pkg::flt(slt_pkg::FC_STRING, clip16(line_r), clip16(col_inc));
          end else begin
            step_o.vld = 1'b1;
            step_o.res = slt_pkg::tok(slt_pkg::TK_DOT, clip16(begin_r), 16'd1);
          end
        end
        slt_pkg::MODE_STRING: begin
          if (b == slt_pkg::CH_QUOTE) begin
            step_o.vld = 1'b1;
            step_o.res = slt_pkg::tok(slt_pkg::TK_STRING, clip16(begin_r), clip16(len_cur));
          end else begin
            step_o.vld = fin;
            step_o.res = slt_pkg::flt(slt_pkg::FC_STRING, clip16(line_r), clip16(col_inc));
          end
        end
        default: begin
          if (lo) begin
            step_o.vld = fin;
            step_o.res = slt_pkg::tok(slt_pkg::TK_WORD, clip16(off_r), clip16(len_start));
          end else if (dg) begin
            step_o.vld = fin;
            step_o.res = slt_pkg::tok(slt_pkg::TK_VALUE, clip16(off_r), clip16(len_start));
          end else if (b == slt_pkg::CH_LPAREN) begin
            step_o.vld = 1'b0;
          end else if (pn) begin
            if (b == slt_pkg::CH_DOT) begin
              step_o.vld = fin;
              step_o.res = slt_pkg::tok(slt_pkg::TK_DOT, clip16(off_r), 16'd1);
            end else if (slt_pkg::is_op(b)) begin
              step_o.vld = 1'b1;
              step_o.res = slt_pkg::tok(slt_pkg::op_kind(b), clip16(off_r), 16'd1);
            end else begin
              step_o.vld = 1'b1;
              step_o.res = slt_pkg::flt(slt_pkg::FC_SYMBOL, clip16(line_r), clip16(col_inc));
            end
          end else if (sp) begin
            step_o.vld = 1'b0;
          end else begin
            step_o.vld = 1'b1;
            step_o.res = slt_pkg::flt(slt_pkg::FC_START, clip16(line_r), clip16(col_r));
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= slt_pkg::MODE_IDLE;
      off_r    <= '0;
      begin_r  <= '0;
      line_r   <= POS_ONE;
      col_r    <= '0;
      prefix_r <= '0;
      fault_r  <= 1'b0;
    end else begin
      mode_r   <= mode_nxt;
      off_r    <= off_nxt;
      begin_r  <= begin_nxt;
      line_r   <= line_nxt;
      col_r    <= col_nxt;
      prefix_r <= prefix_nxt;
      fault_r  <= fault_nxt;
    end
  end

  `SLT_ASSERT_IMPL(a_fault_silent, clk, rst_n, fault_r, !step_o.vld)
  `SLT_ASSERT_NEXT(a_fault_holds, clk, rst_n, fault_r, fault_r && $stable(off_r))
  `SLT_ASSERT_IMPL(a_begin_le_off, clk, rst_n, 1'b1, begin_r <= off_r)
  `SLT_ASSERT_NEXT(a_final_clears, clk, rst_n, go && fin && !fault_nxt,
                   mode_r == slt_pkg::MODE_IDLE && off_r == '0 && line_r == POS_ONE)

endmodule

`default_nettype wire

### rtl/slt_outreg.sv
// Result register of the tokenizer: holds one result word until the sink takes it.
// Depends on slt_pkg.
`default_nettype none

module slt_outreg (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire slt_pkg::step_t step_i,
  input  wire logic           out_stall,
  output logic                slot_free,
  output logic                out_valid,
  output slt_pkg::result_t    res_o
);

  logic             vld_r, vld_nxt;
  slt_pkg::result_t res_r;

  assign slot_free = !vld_r || !out_stall;
  assign vld_nxt   = step_i.vld ? 1'b1 : (vld_r && out_stall);
  assign out_valid = vld_r;
  assign res_o     = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step_i.vld) begin
      res_r <= step_i.res;
    end
  end

endmodule

`default_nettype wire

### rtl/stack_language_tokenizer.sv
// Top level of the stack-language tokenizer: input register, scanner, result register.
// Depends on slt_pkg, slt_inreg, slt_scan and slt_outreg.
//
//   channel   direction   handshake              payload
//   in_       sink        in_valid / in_stall    text_byte, is_final
//   out_      source      out_valid / out_stall  result_kind .. fault_column
//
// One source byte per cycle while no result waits on out_stall; a byte is scanned
// from the input register, and any result word it yields goes to the result register.
// The scanner step against the mode and position registers sets the rate.
// rst_n is synchronous; after reset the block takes a byte at once.
// The input register keeps filling while a result waits on out_stall; it stalls
// only when both registers hold a word.
`default_nettype none

module stack_language_tokenizer #(
  parameter int POS_BITS = slt_pkg::POS_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_text_byte,
  input  wire logic        in_is_final,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_result_kind,
  output logic [4:0]       out_token_kind,
  output logic [15:0]      out_token_offset,
  output logic [15:0]      out_token_length,
  output logic [2:0]       out_fault_code,
  output logic [15:0]      out_fault_line,
  output logic [15:0]      out_fault_column
);

  slt_pkg::item_t   item;
  slt_pkg::step_t   step;
  slt_pkg::result_t res;
  logic             take;
  logic             slot_free;

  slt_inreg u_inreg (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_text_byte (in_text_byte),
    .in_is_final  (in_is_final),
    .take         (take),
    .item_o       (item)
  );

  slt_scan #(
    .POS_BITS (POS_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_i    (item),
    .slot_free (slot_free),
    .take      (take),
    .step_o    (step)
  );

  slt_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .step_i    (step),
    .out_stall (out_stall),
    .slot_free (slot_free),
    .out_valid (out_valid),
    .res_o     (res)
  );

  assign out_result_kind  = res.result_kind;
  assign out_token_kind   = res.token_kind;
  assign out_token_offset = res.token_offset;
  assign out_token_length = res.token_length;
  assign out_fault_code   = res.fault_code;
  assign out_fault_line   = res.fault_line;
  assign out_fault_column = res.fault_column;

endmodule

`default_nettype wire
